// ===== rtl/lap_stopwatch_seven_segment_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the lap stopwatch
// Clocked property checks; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef LAP_STOPWATCH_SEVEN_SEGMENT_MACROS_SVH
`define LAP_STOPWATCH_SEVEN_SEGMENT_MACROS_SVH

`ifndef SYNTHESIS

// check a property at every clock edge outside reset
`define LAPSW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lap stopwatch check failed");

// check a property at every clock edge, reset included
`define LAPSW_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lap stopwatch check failed");

`else

`define LAPSW_ASSERT(label, clk, rst_n, prop)
`define LAPSW_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/lapsw_pkg.sv =====
// ---------------------------------------------------------------------------
// lapsw_pkg
// Shared types, key codes and the seven-segment table of the lap stopwatch.
// ---------------------------------------------------------------------------
package lapsw_pkg;

    // default count limit in hundredths of a second (one hundred minutes)
    localparam int WRAP_LIMIT_DEF = 600000;

    // field widths
    localparam int VALUE_W = 20;
    localparam int SEG_W   = 7;
    localparam int KEY_W   = 4;

    // one-hot key commands
    localparam logic [KEY_W-1:0] KEY_START = 4'b0001;
    localparam logic [KEY_W-1:0] KEY_STOP  = 4'b0010;
    localparam logic [KEY_W-1:0] KEY_LAP   = 4'b0100;
    localparam logic [KEY_W-1:0] KEY_CLEAR = 4'b1000;

    // time value kept as BCD digits, MM:SS.hh
    typedef struct packed {
        logic [3:0] tens_minutes;
        logic [3:0] minutes;
        logic [2:0] tens_seconds;
        logic [3:0] seconds;
        logic [3:0] tenths;
        logic [3:0] hundredths;
    } t_digits;

    // active-high segment code, bit0 is segment a
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h67;
            default: code = 7'h3F;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/lap_stopwatch_seven_segment.sv =====
// ---------------------------------------------------------------------------
// lap_stopwatch_seven_segment
// Lap stopwatch counting hundredths of a second, with MM:SS.hh segment codes.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_tick, i_keys, i_show_lap
//  out     | output    | o_out_valid / i_out_ready  | o_seg_*, o_shown_value
//
//  One transaction per clock while the output is not stalled. Its result sits
//  in the output register from the cycle after acceptance; the count is kept in
//  binary and in BCD digits, so the segment decode is a table lookup per digit.
//  Input ready is high whenever the output register is empty or being drained.
//  Reset (synchronous, active low) stops the watch and zeroes count and lap.
// ---------------------------------------------------------------------------
`include "lap_stopwatch_seven_segment_macros.svh"

module lap_stopwatch_seven_segment #(
    parameter int WRAP_LIMIT = lapsw_pkg::WRAP_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_tick,
    input  logic [lapsw_pkg::KEY_W-1:0]       i_keys,
    input  logic                              i_show_lap,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lapsw_pkg::SEG_W-1:0]       o_seg_tens_minutes,
    output logic [lapsw_pkg::SEG_W-1:0]       o_seg_minutes,
    output logic [lapsw_pkg::SEG_W-1:0]       o_seg_tens_seconds,
    output logic [lapsw_pkg::SEG_W-1:0]       o_seg_seconds,
    output logic [lapsw_pkg::SEG_W-1:0]       o_seg_tenths,
    output logic [lapsw_pkg::SEG_W-1:0]       o_seg_hundredths,
    output logic [lapsw_pkg::VALUE_W-1:0]     o_shown_value
);

    localparam logic [lapsw_pkg::VALUE_W-1:0] WRAP_VAL = lapsw_pkg::VALUE_W'(WRAP_LIMIT);

    // watch state
    logic [lapsw_pkg::VALUE_W-1:0] r_elapsed, n_elapsed;
    logic [lapsw_pkg::VALUE_W-1:0] r_lap, n_lap;
    lapsw_pkg::t_digits            r_elapsed_bcd, n_elapsed_bcd;
    lapsw_pkg::t_digits            r_lap_bcd, n_lap_bcd;
    logic                          r_run, n_run;
    logic                          r_lap_pend, n_lap_pend;
    logic                          r_clr_pend, n_clr_pend;

    // result register
    logic                          r_out_valid;
    logic [lapsw_pkg::SEG_W-1:0]   r_seg_tm, r_seg_m, r_seg_ts, r_seg_s, r_seg_t, r_seg_h;
    logic [lapsw_pkg::VALUE_W-1:0] r_shown;

    logic                          in_accept;
    logic                          key_run, key_lap, key_clr;
    logic [lapsw_pkg::VALUE_W-1:0] bump_bin;
    lapsw_pkg::t_digits            bump_bcd;
    lapsw_pkg::t_digits            shown_bcd;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // key decode: only a one-hot pattern is a command
    always_comb begin
        key_run = r_run;
        key_lap = r_lap_pend;
        key_clr = r_clr_pend;
        unique case (i_keys)
            lapsw_pkg::KEY_START: begin
                key_run = 1'b1;
                key_lap = 1'b0;
                key_clr = 1'b0;
            end
            lapsw_pkg::KEY_STOP: begin
                key_run = 1'b0;
                key_lap = 1'b0;
                key_clr = 1'b0;
            end
            lapsw_pkg::KEY_LAP: begin
                key_lap = 1'b1;
                key_clr = 1'b0;
            end
            lapsw_pkg::KEY_CLEAR: begin
                key_lap = 1'b0;
                key_clr = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // count increment, binary and BCD side by side, wrap at the limit
    always_comb begin
        bump_bin = r_elapsed + 1'b1;
        bump_bcd = r_elapsed_bcd;
        if (bump_bin == WRAP_VAL) begin
            bump_bin = '0;
            bump_bcd = '0;
        end else if (r_elapsed_bcd.hundredths != 4'd9) begin
            bump_bcd.hundredths = r_elapsed_bcd.hundredths + 4'd1;
        end else begin
            bump_bcd.hundredths = '0;
            if (r_elapsed_bcd.tenths != 4'd9) begin
                bump_bcd.tenths = r_elapsed_bcd.tenths + 4'd1;
            end else begin
                bump_bcd.tenths = '0;
                if (r_elapsed_bcd.seconds != 4'd9) begin
                    bump_bcd.seconds = r_elapsed_bcd.seconds + 4'd1;
                end else begin
                    bump_bcd.seconds = '0;
                    if (r_elapsed_bcd.tens_seconds != 3'd5) begin
                        bump_bcd.tens_seconds = r_elapsed_bcd.tens_seconds + 3'd1;
                    end else begin
                        bump_bcd.tens_seconds = '0;
                        if (r_elapsed_bcd.minutes != 4'd9) begin
                            bump_bcd.minutes = r_elapsed_bcd.minutes + 4'd1;
                        end else begin
                            bump_bcd.minutes = '0;
                            if (r_elapsed_bcd.tens_minutes != 4'd9) begin
                                bump_bcd.tens_minutes = r_elapsed_bcd.tens_minutes + 4'd1;
                            end else begin
                                bump_bcd.tens_minutes = '0;
                            end
                        end
                    end
                end
            end
        end
    end

    // tick handling: pending clear, then pending lap, then plain count
    always_comb begin
        n_elapsed     = r_elapsed;
        n_elapsed_bcd = r_elapsed_bcd;
        n_lap         = r_lap;
        n_lap_bcd     = r_lap_bcd;
        n_run         = key_run;
        n_lap_pend    = key_lap;
        n_clr_pend    = key_clr;
        if (i_tick) begin
            if (key_clr) begin
                n_elapsed     = '0;
                n_elapsed_bcd = '0;
                n_lap         = '0;
                n_lap_bcd     = '0;
                n_run         = 1'b0;
                n_clr_pend    = 1'b0;
            end else if (key_lap) begin
                n_lap      = r_elapsed;
                n_lap_bcd  = r_elapsed_bcd;
                n_lap_pend = 1'b0;
                if (key_run) begin
                    n_elapsed     = bump_bin;
                    n_elapsed_bcd = bump_bcd;
                end
            end else if (key_run) begin
                n_elapsed     = bump_bin;
                n_elapsed_bcd = bump_bcd;
            end
        end
    end

    // displayed value is taken before this transaction's tick
    assign shown_bcd = i_show_lap ? r_lap_bcd : r_elapsed_bcd;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed     <= '0;
            r_elapsed_bcd <= '0;
            r_lap         <= '0;
            r_lap_bcd     <= '0;
            r_run         <= 1'b0;
            r_lap_pend    <= 1'b0;
            r_clr_pend    <= 1'b0;
        end else if (in_accept) begin
            r_elapsed     <= n_elapsed;
            r_elapsed_bcd <= n_elapsed_bcd;
            r_lap         <= n_lap;
            r_lap_bcd     <= n_lap_bcd;
            r_run         <= n_run;
            r_lap_pend    <= n_lap_pend;
            r_clr_pend    <= n_clr_pend;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_seg_tm <= lapsw_pkg::seg_of(shown_bcd.tens_minutes);
            r_seg_m  <= lapsw_pkg::seg_of(shown_bcd.minutes);
            r_seg_ts <= lapsw_pkg::seg_of({1'b0, shown_bcd.tens_seconds});
            r_seg_s  <= lapsw_pkg::seg_of(shown_bcd.seconds);
            r_seg_t  <= lapsw_pkg::seg_of(shown_bcd.tenths);
            r_seg_h  <= lapsw_pkg::seg_of(shown_bcd.hundredths);
            r_shown  <= i_show_lap ? r_lap : r_elapsed;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_seg_tens_minutes = r_seg_tm;
    assign o_seg_minutes      = r_seg_m;
    assign o_seg_tens_seconds = r_seg_ts;
    assign o_seg_seconds      = r_seg_s;
    assign o_seg_tenths       = r_seg_t;
    assign o_seg_hundredths   = r_seg_h;
    assign o_shown_value      = r_shown;

    // checks
    `LAPSW_ASSERT(a_count_below_limit, i_clk, i_rst_n, r_elapsed < WRAP_VAL)
    `LAPSW_ASSERT(a_one_pending, i_clk, i_rst_n, !(r_lap_pend && r_clr_pend))
    `LAPSW_ASSERT(a_accept_fills_out, i_clk, i_rst_n, in_accept |=> r_out_valid)
    `LAPSW_ASSERT(a_clear_on_tick, i_clk, i_rst_n,
        (in_accept && i_tick && key_clr) |=> (r_elapsed == '0 && r_lap == '0 && !r_run))
    `LAPSW_ASSERT(a_lap_on_tick, i_clk, i_rst_n,
        (in_accept && i_tick && !key_clr && key_lap) |=> (r_lap == $past(r_elapsed)))

endmodule
